>>> sv/button_click_classifier_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the button click classifier
// Concurrent assertion shorthands on the block clock and reset.
// ----------------------------------------------------------------------------
`ifndef BUTTON_CLICK_CLASSIFIER_TOP_MACROS_SVH
`define BUTTON_CLICK_CLASSIFIER_TOP_MACROS_SVH

// Same-cycle implication, masked while reset is high
`define BCC_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("button classifier assertion failed");

// Next-cycle implication, masked while reset is high
`define BCC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("button classifier assertion failed");

// Implication that also holds across reset
`define BCC_ASSERT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |-> (cons)) \
      else $error("button classifier assertion failed");

`endif

>>> sv/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg
// Types, register indexes and reset constants of the button click classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bcc_pkg;

   localparam int TICK_W  = 16;
   localparam int STATE_W = 3;
   localparam int INDEX_W = 3;

   localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

   // Register reset values
   localparam logic              RST_ACTIVE_LEVEL    = 1'b0;
   localparam logic [TICK_W-1:0] RST_FILTER_TICKS    = 16'd25;
   localparam logic [TICK_W-1:0] RST_DOUBLE_TICKS    = 16'd500;
   localparam logic [TICK_W-1:0] RST_LONG_TICKS      = 16'd2000;
   localparam logic [TICK_W-1:0] RST_VERY_LONG_TICKS = 16'd10000;

   // Register indexes
   typedef enum logic [INDEX_W-1:0] {
      REG_ACTIVE_LEVEL    = 3'd0,
      REG_FILTER_TICKS    = 3'd1,
      REG_DOUBLE_TICKS    = 3'd2,
      REG_LONG_TICKS      = 3'd3,
      REG_VERY_LONG_TICKS = 3'd4
   } bcc_reg_type;

   // Controller phases
   typedef enum logic [2:0] {
      PH_INIT          = 3'd0,
      PH_WAIT_PRESS    = 3'd1,
      PH_WAIT_RELEASE  = 3'd2,
      PH_WAIT_PRESS2   = 3'd3,
      PH_WAIT_RELEASE2 = 3'd4
   } bcc_phase_type;

   // Published button states
   typedef enum logic [STATE_W-1:0] {
      BS_NONE      = 3'd0,
      BS_PRESSED   = 3'd1,
      BS_CLICK     = 3'd2,
      BS_DOUBLE    = 3'd3,
      BS_LONG      = 3'd4,
      BS_VERY_LONG = 3'd5
   } bcc_bstate_type;

   typedef struct packed {
      logic              active_level;
      logic [TICK_W-1:0] filter_ticks;
      logic [TICK_W-1:0] double_ticks;
      logic [TICK_W-1:0] long_ticks;
      logic [TICK_W-1:0] very_long_ticks;
   } bcc_cfg_type;

   typedef struct packed {
      bcc_bstate_type button_state;
      logic           state_written;
   } bcc_result_type;

endpackage

>>> sv/bcc_csr.sv
// ----------------------------------------------------------------------------
// bcc_csr
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcc_csr
   import bcc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [INDEX_W-1:0]  csr_index,
   input  logic [TICK_W-1:0]   csr_wdata,
   output bcc_cfg_type         cfg
);

   bcc_cfg_type cfg_ff;
   bcc_cfg_type cfg_in;

   // Decode the write; indexes past the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_ACTIVE_LEVEL:    cfg_in.active_level    = csr_wdata[0];
            REG_FILTER_TICKS:    cfg_in.filter_ticks    = csr_wdata;
            REG_DOUBLE_TICKS:    cfg_in.double_ticks    = csr_wdata;
            REG_LONG_TICKS:      cfg_in.long_ticks      = csr_wdata;
            REG_VERY_LONG_TICKS: cfg_in.very_long_ticks = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_level    <= RST_ACTIVE_LEVEL;
         cfg_ff.filter_ticks    <= RST_FILTER_TICKS;
         cfg_ff.double_ticks    <= RST_DOUBLE_TICKS;
         cfg_ff.long_ticks      <= RST_LONG_TICKS;
         cfg_ff.very_long_ticks <= RST_VERY_LONG_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> sv/bcc_fsm.sv
// ----------------------------------------------------------------------------
// bcc_fsm
// Press and release controller with tick counter and click classification.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcc_fsm
   import bcc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  logic           pin_level,
   input  bcc_cfg_type    cfg,
   output bcc_result_type result
);

   bcc_phase_type     phase_ff, phase_in;
   logic [TICK_W-1:0] elapsed_ff, elapsed_in;
   bcc_bstate_type    pub_ff, pub_in;

   logic              pressed;
   logic [TICK_W-1:0] elapsed_inc;
   logic              written;

   assign pressed     = (pin_level == cfg.active_level);
   assign elapsed_inc = (elapsed_ff == TICK_MAX) ? elapsed_ff : elapsed_ff + 1'b1;

   // Next phase, counter and published state for one tick
   always_comb begin
      phase_in   = phase_ff;
      elapsed_in = elapsed_inc;
      pub_in     = pub_ff;
      written    = 1'b0;
      unique case (phase_ff)
         PH_WAIT_PRESS: begin
            if (pressed) begin
               pub_in     = BS_PRESSED;
               written    = 1'b1;
               elapsed_in = '0;
               phase_in   = PH_WAIT_RELEASE;
            end
         end
         PH_WAIT_RELEASE: begin
            if (!pressed) begin
               // bounce filter first, then very long, then long
               priority if (elapsed_inc < cfg.filter_ticks) begin
                  phase_in = PH_WAIT_PRESS;
               end else if (elapsed_inc >= cfg.very_long_ticks) begin
                  pub_in   = BS_VERY_LONG;
                  written  = 1'b1;
                  phase_in = PH_WAIT_PRESS;
               end else if (elapsed_inc >= cfg.long_ticks) begin
                  pub_in   = BS_LONG;
                  written  = 1'b1;
                  phase_in = PH_WAIT_PRESS;
               end else begin
                  pub_in     = BS_NONE;
                  written    = 1'b1;
                  elapsed_in = '0;
                  phase_in   = PH_WAIT_PRESS2;
               end
            end
         end
         PH_WAIT_PRESS2: begin
            priority if (pressed) begin
               pub_in     = BS_PRESSED;
               written    = 1'b1;
               elapsed_in = '0;
               phase_in   = PH_WAIT_RELEASE2;
            end else if (elapsed_inc > cfg.double_ticks) begin
               pub_in   = BS_CLICK;
               written  = 1'b1;
               phase_in = PH_WAIT_PRESS;
            end
         end
         PH_WAIT_RELEASE2: begin
            if (!pressed) begin
               written = 1'b1;
               if (elapsed_inc < cfg.filter_ticks) begin
                  pub_in   = BS_NONE;
                  phase_in = PH_WAIT_PRESS2;
               end else begin
                  pub_in   = BS_DOUBLE;
                  phase_in = PH_WAIT_PRESS;
               end
            end
         end
         default: begin
            // init: hold off until the button is seen released
            phase_in = pressed ? PH_INIT : PH_WAIT_PRESS;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_INIT;
         elapsed_ff <= '0;
         pub_ff     <= BS_NONE;
      end else if (step) begin
         phase_ff   <= phase_in;
         elapsed_ff <= elapsed_in;
         pub_ff     <= pub_in;
      end
   end

   assign result.button_state  = pub_in;
   assign result.state_written = written;

endmodule

>>> sv/button_click_classifier_top.sv
// ----------------------------------------------------------------------------
// button_click_classifier_top
// Classifies millisecond pin samples into press, click, double, long, very long clicks.
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | payload
//  req     | in  | req_tvalid/req_tready  | tdata[0] pin_level
//  rsp     | out | rsp_tvalid/rsp_tready  | tdata[2:0] button_state,
//          |     |                        | tuser[0] state_written
//  csr     | in  | csr_we                 | csr_index, csr_wdata
//
//  One item per cycle sustained while rsp_tready is high; each accepted item
//  passes the input register, controller logic and result register in turn.
//  The controller state steps once per item as it leaves the input register.
//  Reset is synchronous and active high; it clears both stage valids, the
//  controller and the configuration registers.
//  A stalled result holds the pipeline; req_tready falls only when both
//  stages are full and rsp_tready is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_click_classifier_top
   import bcc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // input items
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // [0] pin_level
   // result items
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,   // [2:0] button_state
   output logic [0:0]          rsp_tuser,   // [0] state_written
   // configuration
   input  logic                csr_we,
   input  logic [INDEX_W-1:0]  csr_index,
   input  logic [TICK_W-1:0]   csr_wdata
);

   bcc_cfg_type    cfg;
   bcc_result_type result;

   logic           in_valid_ff, in_valid_in;
   logic           in_pin_ff;
   logic           out_valid_ff, out_valid_in;
   bcc_result_type out_ff;
   logic           advance;

   // Pipeline flow control
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || advance;
   assign in_valid_in  = req_tvalid ? 1'b1 : (in_valid_ff && !advance);
   assign out_valid_in = advance ? 1'b1 : (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= in_valid_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_pin_ff <= req_tdata[0];
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   bcc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bcc_fsm u_fsm (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .pin_level (in_pin_ff),
      .cfg       (cfg),
      .result    (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b0, out_ff.button_state};
   assign rsp_tuser  = out_ff.state_written;

endmodule

>>> sv/bcc_checker.sv
// ----------------------------------------------------------------------------
// bcc_checker
// Port-level checks of the button click classifier, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "button_click_classifier_top_macros.svh"

module bcc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [0:0] rsp_tuser
);

   logic req_accept;

   assign req_accept = req_tvalid && req_tready;

   // a stalled result holds its payload
   `BCC_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // every accepted item is followed by a valid result once through both registers
   `BCC_ASSERT_IMPL(a_latency, req_accept, ##2 rsp_tvalid)

   // input back-pressure only comes from a stalled result
   `BCC_ASSERT_IMPL(a_backpressure, !req_tready, rsp_tvalid && !rsp_tready)

   // both sides come out of reset empty and ready
   `BCC_ASSERT_ALWAYS(a_reset_empty, $past(reset) && !reset,
      req_tready && !rsp_tvalid)

endmodule

bind button_click_classifier_top bcc_checker u_bcc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
